### src/interval_set_disjoint_pair_check_core_macros.svh
// Assertion macros shared by the checker of the disjoint-pair core
`ifndef INTERVAL_SET_DISJOINT_PAIR_CHECK_CORE_MACROS_SVH
`define INTERVAL_SET_DISJOINT_PAIR_CHECK_CORE_MACROS_SVH

// Check that a property holds at every rising edge outside reset
`define ISDPC_ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an expression is never true outside reset
`define ISDPC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### src/isdpc_pkg.sv
// Types and constants shared by the disjoint-pair core and its cells
`timescale 1ns / 1ps

package isdpc_pkg;

  localparam int END_W       = 32;
  localparam int COUNT_OUT_W = 7;
  localparam int COUNT_MAX   = 127;

  // Request kind
  typedef enum logic [0:0] {
    KIND_ADD    = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NO_MATCH = 2'd2
  } status_t;

  // Request wave travelling down the chain of slots
  typedef struct packed {
    logic             vld;
    kind_t            kind;
    logic             done;
    logic [END_W-1:0] left_end;
    logic [END_W-1:0] right_end;
    logic [END_W-1:0] min_right;
    logic [END_W-1:0] max_left;
  } wave_t;

endpackage

### src/isdpc_cell.sv
// One slot of the interval table: updates itself and folds into the running min/max
`timescale 1ns / 1ps

module isdpc_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  isdpc_pkg::wave_t wave_in,
  output isdpc_pkg::wave_t wave_out
);

  logic                         slot_valid_r, slot_valid_nxt;
  logic [isdpc_pkg::END_W-1:0]  slot_left_r, slot_left_nxt;
  logic [isdpc_pkg::END_W-1:0]  slot_right_r, slot_right_nxt;
  isdpc_pkg::wave_t             wave_r, wave_nxt;
  logic                         take_add;
  logic                         take_rem;

  // Claim the slot for an add, or clear it on the first matching remove
  always_comb begin
    take_add = wave_in.vld && !wave_in.done &&
               (wave_in.kind == isdpc_pkg::KIND_ADD) && !slot_valid_r;
    take_rem = wave_in.vld && !wave_in.done &&
               (wave_in.kind == isdpc_pkg::KIND_REMOVE) && slot_valid_r &&
               (slot_left_r == wave_in.left_end) && (slot_right_r == wave_in.right_end);
    slot_valid_nxt = slot_valid_r;
    slot_left_nxt  = slot_left_r;
    slot_right_nxt = slot_right_r;
    if (take_add) begin
      slot_valid_nxt = 1'b1;
      slot_left_nxt  = wave_in.left_end;
      slot_right_nxt = wave_in.right_end;
    end else if (take_rem) begin
      slot_valid_nxt = 1'b0;
    end
  end

  // Pass the request on, folding this slot's updated contents into min/max
  always_comb begin
    wave_nxt      = wave_in;
    wave_nxt.done = wave_in.done || take_add || take_rem;
    if (slot_valid_nxt && (slot_right_nxt < wave_in.min_right)) begin
      wave_nxt.min_right = slot_right_nxt;
    end
    if (slot_valid_nxt && (slot_left_nxt > wave_in.max_left)) begin
      wave_nxt.max_left = slot_left_nxt;
    end
  end

  // Hold slot and wave registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= 1'b0;
      wave_r.vld   <= 1'b0;
    end else begin
      if (wave_in.vld) begin
        slot_valid_r <= slot_valid_nxt;
      end
      wave_r.vld <= wave_nxt.vld;
    end
    slot_left_r       <= slot_left_nxt;
    slot_right_r      <= slot_right_nxt;
    wave_r.kind       <= wave_nxt.kind;
    wave_r.done       <= wave_nxt.done;
    wave_r.left_end   <= wave_nxt.left_end;
    wave_r.right_end  <= wave_nxt.right_end;
    wave_r.min_right  <= wave_nxt.min_right;
    wave_r.max_left   <= wave_nxt.max_left;
  end

  assign wave_out = wave_r;

endmodule

### src/interval_set_disjoint_pair_check_core.sv
// Top level of the disjoint-pair checker over a multiset of closed intervals
//
//  channel   ports                                              handshake
//  request   in_kind, in_left_end, in_right_end                 start high, busy low
//  result    out_has_disjoint_pair, out_status, out_active_count  out_valid strobe
//
// A request walks the chain of TABLE_SLOTS cells, each of which registers it; its result
// is registered once more after the last cell and then strobes. The chain takes one request
// every cycle, so busy stays low and requests queue up behind each other.
// Reset (rst_n low, synchronous) clears all slot valid bits, the count and any
// request in flight. The receiver cannot stall: each result shows for one cycle.
`timescale 1ns / 1ps

module interval_set_disjoint_pair_check_core #(
  parameter int TABLE_SLOTS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_kind,
  input  logic [isdpc_pkg::END_W-1:0]        in_left_end,
  input  logic [isdpc_pkg::END_W-1:0]        in_right_end,
  output logic                               out_valid,
  output logic                               out_has_disjoint_pair,
  output logic [1:0]                         out_status,
  output logic [isdpc_pkg::COUNT_OUT_W-1:0]  out_active_count
);

  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam int EXT_W = (CNT_W > isdpc_pkg::COUNT_OUT_W) ? CNT_W : isdpc_pkg::COUNT_OUT_W;

  isdpc_pkg::wave_t                     chain [TABLE_SLOTS+1];
  isdpc_pkg::wave_t                     tail;
  logic [CNT_W-1:0]                     count_r, count_nxt;
  logic [EXT_W-1:0]                     count_ext;
  isdpc_pkg::status_t                   status_nxt;
  logic                                 pair_nxt;
  logic                                 out_valid_r;
  logic                                 out_pair_r;
  isdpc_pkg::status_t                   out_status_r;
  logic [isdpc_pkg::COUNT_OUT_W-1:0]    out_count_r, out_count_nxt;

  // The chain takes a request in every cycle
  assign busy = 1'b0;

  // Launch a fresh request into the head of the chain
  always_comb begin
    chain[0].vld       = start && !busy;
    chain[0].kind      = isdpc_pkg::kind_t'(in_kind);
    chain[0].done      = 1'b0;
    chain[0].left_end  = in_left_end;
    chain[0].right_end = in_right_end;
    chain[0].min_right = '1;
    chain[0].max_left  = '0;
  end

  // Row of slot cells
  for (genvar gi = 0; gi < TABLE_SLOTS; gi++) begin : g_cell
    isdpc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wave_in  (chain[gi]),
      .wave_out (chain[gi+1])
    );
  end

  assign tail = chain[TABLE_SLOTS];

  // Resolve status, count and the disjoint test at the end of the chain
  always_comb begin
    count_nxt  = count_r;
    status_nxt = isdpc_pkg::STATUS_OK;
    if (tail.done) begin
      if (tail.kind == isdpc_pkg::KIND_ADD) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        count_nxt = count_r - CNT_W'(1);
      end
    end else if (tail.kind == isdpc_pkg::KIND_ADD) begin
      status_nxt = isdpc_pkg::STATUS_FULL;
    end else begin
      status_nxt = isdpc_pkg::STATUS_NO_MATCH;
    end
    pair_nxt  = (count_nxt >= CNT_W'(2)) && (tail.min_right < tail.max_left);
    count_ext = EXT_W'(count_nxt);
    if (count_ext > EXT_W'(isdpc_pkg::COUNT_MAX)) begin
      out_count_nxt = isdpc_pkg::COUNT_OUT_W'(isdpc_pkg::COUNT_MAX);
    end else begin
      out_count_nxt = count_ext[isdpc_pkg::COUNT_OUT_W-1:0];
    end
  end

  // Hold the count and register the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (tail.vld) begin
        count_r <= count_nxt;
      end
      out_valid_r <= tail.vld;
    end
    out_pair_r   <= pair_nxt;
    out_status_r <= status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_has_disjoint_pair = out_pair_r;
  assign out_status            = out_status_r;
  assign out_active_count      = out_count_r;

endmodule

### src/isdpc_checker.sv
// Port-level checks for the disjoint-pair core, bound to the top level
`timescale 1ns / 1ps
`include "interval_set_disjoint_pair_check_core_macros.svh"

module isdpc_checker #(
  parameter int TABLE_SLOTS = 64
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic                               out_has_disjoint_pair,
  input logic [1:0]                         out_status,
  input logic [isdpc_pkg::COUNT_OUT_W-1:0]  out_active_count
);

  localparam int LAT = TABLE_SLOTS + 1;

  logic taken;
  logic few_live;
  logic is_full;
  logic status_known;

  // Decode the port values the checks look at
  assign taken        = start && !busy && rst_n;
  assign few_live     = (out_active_count < isdpc_pkg::COUNT_OUT_W'(2));
  assign is_full      = (out_status == isdpc_pkg::STATUS_FULL);
  assign status_known = (out_status == isdpc_pkg::STATUS_OK) ||
                        (out_status == isdpc_pkg::STATUS_FULL) ||
                        (out_status == isdpc_pkg::STATUS_NO_MATCH);

  // A result only follows a request that was taken, after its walk down the chain
  `ISDPC_ASSERT_HOLDS(a_result_has_request, out_valid |-> $past(taken, LAT), "stray result")

  // A disjoint pair needs at least two active intervals
  `ISDPC_ASSERT_NEVER(a_pair_two, out_valid && out_has_disjoint_pair && few_live, "pair, few")

  // A dropped add means the table is full, so the count is not small
  `ISDPC_ASSERT_NEVER(a_full_not_empty, out_valid && is_full && few_live, "full on sparse table")

  // Only the three defined status codes appear
  `ISDPC_ASSERT_NEVER(a_status_code, out_valid && !status_known, "undefined status code")

endmodule

bind interval_set_disjoint_pair_check_core isdpc_checker #(
  .TABLE_SLOTS(TABLE_SLOTS)
) u_isdpc_checker (.*);
